[hw/rtl/mepq_pkg.sv]
// Shared types and constants for the max-extract priority queue.
package mepq_pkg;

    // Number of entries the queue can hold
    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_REMOVED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Command transaction
    typedef struct packed {
        action_t                     action;
        logic signed [VALUE_W-1:0]   item_value;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        status_t                     status;
        logic signed [VALUE_W-1:0]   removed_value;
    } rsp_t;

endpackage

[hw/rtl/max_extract_priority_queue.sv]
// Top level of the max-extract priority queue: sequencer, entry RAM, result register.
//
//  channel  | ports               | handshake
//  ---------+---------------------+-----------------------------------------
//  command  | start, busy, cmd    | taken on an edge with start=1, busy=0
//  result   | done, result        | done high one cycle, always taken
//
// An enqueue is handled in the idle state; its result appears the cycle after it is taken.
// A dequeue on N held entries scans them with one read per cycle through
// the single read port of the entry RAM, then refills the freed slot with
// the tail entry. A dequeue on an empty queue returns EMPTY with no scan.
// Reset empties the queue at once; entry contents are not cleared.
// The receiver cannot stall; each result is flagged by done for exactly one cycle.
module max_extract_priority_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mepq_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done,
    output mepq_pkg::rsp_t  result
);

    import mepq_pkg::*;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [VALUE_W-1:0]   rd_data;
    logic                 rsp_valid;
    rsp_t                 rsp;
    logic                 done_reg;
    rsp_t                 result_reg;

    mepq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    mepq_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (VALUE_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rsp_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (rsp_valid)
        begin
            result_reg <= rsp;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hw/rtl/mepq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mepq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/mepq_ctrl.sv]
// Sequencer: enqueue write, dequeue scan for the maximum, and slot refill.
module mepq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mepq_pkg::cmd_t                cmd,
    output logic                          busy,
    output logic                          rsp_valid,
    output mepq_pkg::rsp_t                rsp,
    output logic                          wr_en,
    output logic [mepq_pkg::ADDR_W-1:0]   wr_addr,
    output logic [mepq_pkg::VALUE_W-1:0]  wr_data,
    output logic                          rd_en,
    output logic [mepq_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [mepq_pkg::VALUE_W-1:0]  rd_data
);

    import mepq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MOVE = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next;
    logic [ADDR_W-1:0]          best_idx_reg, best_idx_next;
    logic signed [VALUE_W-1:0]  best_val_reg, best_val_next;
    logic [VALUE_W-1:0]         last_val_reg, last_val_next;
    logic [ADDR_W-1:0]          last_idx;
    logic [CNT_W-1:0]           count_dec;

    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[ADDR_W-1:0];
    assign busy      = (state_reg != S_IDLE);

    // Next-state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        last_val_next = last_val_reg;
        wr_en         = 1'b0;
        wr_addr       = best_idx_reg;
        wr_data       = last_val_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        rsp_valid     = 1'b0;
        rsp.status        = ST_ADDED;
        rsp.removed_value = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.action == ACT_ENQUEUE)
                    begin
                        rsp_valid = 1'b1;
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            rsp.status = ST_FULL;
                        end
                        else
                        begin
                            // Append at the tail
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[ADDR_W-1:0];
                            wr_data    = cmd.item_value;
                            count_next = count_reg + CNT_W'(1);
                            rsp.status = ST_ADDED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_valid  = 1'b1;
                        rsp.status = ST_EMPTY;
                    end
                    else
                    begin
                        // Launch read of the first entry
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Running max; first entry seeds it
                if ((idx_reg == '0) || ($signed(rd_data) > best_val_reg))
                begin
                    best_val_next = $signed(rd_data);
                    best_idx_next = idx_reg;
                end
                if (idx_reg == last_idx)
                begin
                    last_val_next = rd_data;
                    state_next    = S_MOVE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + ADDR_W'(1);
                end
            end

            S_MOVE:
            begin
                // Tail entry fills the freed slot
                wr_en             = 1'b1;
                count_next        = count_dec;
                rsp_valid         = 1'b1;
                rsp.status        = ST_REMOVED;
                rsp.removed_value = best_val_reg;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Scan datapath
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        last_val_reg <= last_val_next;
    end

endmodule
